// ===== rtl/lmtf_pkg.sv =====
// ----------------------------------------------------------------------------
// lmtf_pkg
// Shared sizes and the link type that runs along the row of list cells.
// ----------------------------------------------------------------------------
package lmtf_pkg;

  localparam int MAX_ENTRIES = 8;

  localparam int KEY_W  = 32;
  localparam int CFG_W  = 4;
  localparam int HPOS_W = 3;
  localparam int OCC_W  = 4;

  localparam int IDX_W  = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);

  localparam logic [CFG_W-1:0] CAP_RESET = CFG_W'(3);

  typedef struct packed {
    logic             found;
    logic [IDX_W-1:0] pos;
    logic [KEY_W-1:0] tail;
  } lmtf_link_t;

endpackage

// ===== rtl/lru_move_to_front_cache.sv =====
// ----------------------------------------------------------------------------
// lru_move_to_front_cache
// Recency-ordered key list with hit reporting and tail eviction.
// ----------------------------------------------------------------------------
// One access per clock: each cell compares its key with the access key and
// the row shifts toward the tail (on a hit, down to the hit cell) in the same
// cycle, so an access is taken each cycle while the result register is free
// or being drained. Results appear in the cycle after the access transfer and
// hold while result_stall_i is high; access_stall_o is raised only then.
// Capacity is clamped to 1..MAX_ENTRIES; writing it empties the list at once.
// ----------------------------------------------------------------------------
module lru_move_to_front_cache (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               capacity_we_i,
  input  logic        [lmtf_pkg::CFG_W-1:0]  capacity_wdata_i,
  input  logic                               access_valid_i,
  output logic                               access_stall_o,
  input  logic signed [lmtf_pkg::KEY_W-1:0]  access_key_i,
  output logic                               result_valid_o,
  input  logic                               result_stall_i,
  output logic                               hit_o,
  output logic        [lmtf_pkg::HPOS_W-1:0] hit_position_o,
  output logic                               evicted_valid_o,
  output logic signed [lmtf_pkg::KEY_W-1:0]  evicted_key_o,
  output logic        [lmtf_pkg::OCC_W-1:0]  occupancy_o
);

  localparam int N = lmtf_pkg::MAX_ENTRIES;

  logic [lmtf_pkg::CFG_W-1:0] cap_q;
  logic [lmtf_pkg::CNT_W-1:0] count_q, count_d;
  logic [lmtf_pkg::CNT_W-1:0] cap_eff;
  logic                       out_valid_q;
  logic                       go;
  logic [lmtf_pkg::KEY_W-1:0] key_in;

  logic [lmtf_pkg::KEY_W-1:0] cell_key [N];
  lmtf_pkg::lmtf_link_t       link [N+1];

  logic                       hit_d, evicted_d;

  logic                        hit_q, evicted_q;
  logic [lmtf_pkg::HPOS_W-1:0] hpos_q;
  logic [lmtf_pkg::KEY_W-1:0]  ekey_q;
  logic [lmtf_pkg::OCC_W-1:0]  occ_q;

  assign key_in         = access_key_i;
  assign access_stall_o = out_valid_q && result_stall_i;
  assign go             = access_valid_i && !access_stall_o;

  always_comb begin
    if (cap_q == '0) begin
      cap_eff = lmtf_pkg::CNT_W'(1);
    end else if (32'(cap_q) > 32'(N)) begin
      cap_eff = lmtf_pkg::CNT_W'(N);
    end else begin
      cap_eff = lmtf_pkg::CNT_W'(cap_q);
    end
  end

  assign link[0] = '{found: 1'b0, pos: '0, tail: '0};

  for (genvar i = 0; i < N; i++) begin : g_cell
    lmtf_cell u_cell (
      .clk_i        (clk_i),
      .idx_i        (lmtf_pkg::IDX_W'(i)),
      .go_i         (go),
      .access_key_i (key_in),
      .key_i        ((i == 0) ? key_in : cell_key[(i == 0) ? 0 : i-1]),
      .count_i      (count_q),
      .cap_i        (cap_eff),
      .link_i       (link[i]),
      .key_o        (cell_key[i]),
      .link_o       (link[i+1])
    );
  end

  assign hit_d     = link[N].found;
  assign evicted_d = !hit_d && (count_q == cap_eff);

  always_comb begin
    count_d = count_q;
    if (!hit_d && (count_q < cap_eff)) begin
      count_d = lmtf_pkg::CNT_W'(count_q + 1'b1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q       <= lmtf_pkg::CAP_RESET;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (capacity_we_i) begin
        cap_q   <= capacity_wdata_i;
        count_q <= '0;
      end else if (go) begin
        count_q <= count_d;
      end
      if (go) begin
        out_valid_q <= 1'b1;
      end else if (!result_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (go) begin
      hit_q     <= hit_d;
      hpos_q    <= hit_d ? lmtf_pkg::HPOS_W'(link[N].pos) : '0;
      evicted_q <= evicted_d;
      ekey_q    <= evicted_d ? link[N].tail : '0;
      occ_q     <= lmtf_pkg::OCC_W'(count_d);
    end
  end

  assign result_valid_o  = out_valid_q;
  assign hit_o           = hit_q;
  assign hit_position_o  = hpos_q;
  assign evicted_valid_o = evicted_q;
  assign evicted_key_o   = ekey_q;
  assign occupancy_o     = occ_q;

endmodule

// ===== rtl/lmtf_cell.sv =====
// ----------------------------------------------------------------------------
// lmtf_cell
// One list position: holds a key, compares it against the access key and
// loads the previous cell's key (the head loads the access key) on a shift.
// ----------------------------------------------------------------------------
module lmtf_cell (
  input  logic                          clk_i,
  input  logic [lmtf_pkg::IDX_W-1:0]    idx_i,
  input  logic                          go_i,
  input  logic [lmtf_pkg::KEY_W-1:0]    access_key_i,
  input  logic [lmtf_pkg::KEY_W-1:0]    key_i,
  input  logic [lmtf_pkg::CNT_W-1:0]    count_i,
  input  logic [lmtf_pkg::CNT_W-1:0]    cap_i,
  input  lmtf_pkg::lmtf_link_t          link_i,
  output logic [lmtf_pkg::KEY_W-1:0]    key_o,
  output lmtf_pkg::lmtf_link_t          link_o
);

  logic [lmtf_pkg::KEY_W-1:0] key_q;
  logic [lmtf_pkg::KEY_W-1:0] key_d;
  logic [lmtf_pkg::CNT_W-1:0] idx_w;
  logic                       match;
  logic                       shift;
  logic                       is_tail;

  assign idx_w   = lmtf_pkg::CNT_W'(idx_i);
  assign match   = (idx_w < count_i) && (key_q == access_key_i);
  assign shift   = !link_i.found && (idx_w < cap_i);
  assign is_tail = (idx_w == lmtf_pkg::CNT_W'(cap_i - 1'b1));

  always_comb begin
    link_o.found = link_i.found | match;
    link_o.pos   = link_i.found ? link_i.pos : idx_i;
    link_o.tail  = is_tail ? key_q : link_i.tail;
  end

  assign key_d = (go_i && shift) ? key_i : key_q;

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
  end

  assign key_o = key_q;

endmodule
